/* hw/rtl/resbk_pkg.sv */
// ----------------------------------------------------------------------------
// resbk_pkg
// shared types, constants and helpers for the record exchange sort block
// ----------------------------------------------------------------------------
`default_nettype none

package resbk_pkg;

    localparam int C_CAPACITY = 64;
    localparam int C_KEY_W    = 2;
    localparam int C_SCORE_W  = 8;
    localparam int C_ID_W     = 16;

    // key selector codes
    localparam logic [C_KEY_W-1:0] C_KEY_FIRST  = 2'd0;
    localparam logic [C_KEY_W-1:0] C_KEY_SECOND = 2'd1;

    typedef struct packed {
        logic [C_ID_W-1:0]    record_id;
        logic [C_SCORE_W-1:0] score_first;
        logic [C_SCORE_W-1:0] score_second;
        logic [C_SCORE_W-1:0] score_third;
        logic                 end_of_set;
    } t_in_item;

    typedef struct packed {
        logic [C_ID_W-1:0]    out_id;
        logic [C_SCORE_W-1:0] out_first;
        logic [C_SCORE_W-1:0] out_second;
        logic [C_SCORE_W-1:0] out_third;
        logic                 out_last;
    } t_out_item;

    // one stored record, 40 bits
    typedef struct packed {
        logic [C_ID_W-1:0]    id;
        logic [C_SCORE_W-1:0] first;
        logic [C_SCORE_W-1:0] second;
        logic [C_SCORE_W-1:0] third;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_CAP,
        S_SCAN,
        S_WB,
        S_OUT,
        S_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic row_rd;
        logic row_cap;
        logic scan;
        logic wb;
        logic out;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_row;
        logic pend;
        logic last_issue;
    } t_sts;

    function automatic logic [C_SCORE_W-1:0] key_of(input t_rec rec,
                                                    input logic [C_KEY_W-1:0] sel);
        logic [C_SCORE_W-1:0] k;
        case (sel)
            C_KEY_FIRST:  k = rec.first;
            C_KEY_SECOND: k = rec.second;
            default:      k = rec.third;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/resbk_ctrl.sv */
// ----------------------------------------------------------------------------
// resbk_ctrl
// sequencer for load, exchange sort passes and output run
// ----------------------------------------------------------------------------
`default_nettype none

module resbk_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            i_end_of_set,
    input  wire resbk_pkg::t_sts i_sts,
    output resbk_pkg::t_cmd      o_cmd,
    output logic                 busy
);
    import resbk_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_end_of_set) n_state = S_ROW;
            end
            S_ROW:   n_state = S_CAP;
            S_CAP:   n_state = S_SCAN;
            S_SCAN: begin
                if (!i_sts.pend) n_state = S_WB;
            end
            S_WB: begin
                n_state = i_sts.last_row ? S_OUT : S_ROW;
            end
            S_OUT: begin
                if (i_sts.last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_ROW:   o_cmd.row_rd  = 1'b1;
            S_CAP:   o_cmd.row_cap = 1'b1;
            S_SCAN:  o_cmd.scan    = 1'b1;
            S_WB:    o_cmd.wb      = 1'b1;
            S_OUT:   o_cmd.out     = 1'b1;
            S_DRAIN: o_cmd.clear   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/resbk_dp.sv */
// ----------------------------------------------------------------------------
// resbk_dp
// record memory, row and column counters, compare and swap datapath
// ----------------------------------------------------------------------------
`default_nettype none

module resbk_dp #(
    parameter int CAPACITY = resbk_pkg::C_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire resbk_pkg::t_cmd               i_cmd,
    input  wire resbk_pkg::t_in_item           i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [resbk_pkg::C_KEY_W-1:0] i_cfg_data,
    output resbk_pkg::t_sts                    o_sts,
    output logic                               o_strobe,
    output resbk_pkg::t_out_item               o_result
);
    import resbk_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_rec r_mem [CAPACITY];
    t_rec r_rdata;
    t_rec r_cur;

    logic [C_KEY_W-1:0] r_key;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_i;
    logic [CNT_W-1:0]   r_j;
    logic [ADDR_W-1:0]  r_jd;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_k;
    logic               r_ov;
    logic               r_olast;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_rec              wr_data;
    t_rec              in_rec;
    logic              has_room;
    logic              j_in;
    logic              swap;

    assign in_rec   = '{id: i_item.record_id, first: i_item.score_first,
                        second: i_item.score_second, third: i_item.score_third};
    assign has_room = r_cnt < CNT_W'(CAPACITY);
    assign j_in     = r_j < r_cnt;
    assign swap     = r_pend && (key_of(r_cur, r_key) < key_of(r_rdata, r_key));

    assign o_sts.last_row   = (CNT_W'(r_i) + CNT_W'(1)) == r_cnt;
    assign o_sts.pend       = r_pend;
    assign o_sts.last_issue = (CNT_W'(r_k) + CNT_W'(1)) == r_cnt;

    // memory port control
    always_comb begin
        rd_addr = r_j[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_jd;
        wr_data = r_cur;
        if (i_cmd.load) begin
            wr_en   = has_room;
            wr_addr = r_cnt[ADDR_W-1:0];
            wr_data = in_rec;
        end else if (i_cmd.row_rd) begin
            rd_addr = r_i;
        end else if (i_cmd.scan) begin
            wr_en = swap;
        end else if (i_cmd.wb) begin
            wr_en   = 1'b1;
            wr_addr = r_i;
        end else if (i_cmd.out) begin
            rd_addr = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_cap) begin
            r_cur <= r_rdata;
        end else if (i_cmd.scan && swap) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.row_cap || i_cmd.scan) r_jd <= r_j[ADDR_W-1:0];
        if (i_cmd.out) r_olast <= o_sts.last_issue;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_cnt  <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_pend <= 1'b0;
            r_k    <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) r_key <= i_cfg_data;
            r_ov <= i_cmd.out;
            if (i_cmd.load && has_room) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.row_rd) r_j <= CNT_W'(r_i) + CNT_W'(1);
            if (i_cmd.row_cap || i_cmd.scan) begin
                r_pend <= j_in;
                if (j_in) r_j <= r_j + CNT_W'(1);
            end
            if (i_cmd.wb) begin
                r_i <= o_sts.last_row ? '0 : r_i + ADDR_W'(1);
            end
            if (i_cmd.out) r_k <= r_k + ADDR_W'(1);
            if (i_cmd.clear) begin
                r_cnt <= '0;
                r_k   <= '0;
            end
        end
    end

    assign o_strobe            = r_ov;
    assign o_result.out_id     = r_rdata.id;
    assign o_result.out_first  = r_rdata.first;
    assign o_result.out_second = r_rdata.second;
    assign o_result.out_third  = r_rdata.third;
    assign o_result.out_last   = r_olast;

endmodule

`default_nettype wire

/* hw/rtl/record_exchange_sort_by_key_top.sv */
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key_top
// collects records and emits them in descending order of a selected score
// ----------------------------------------------------------------------------
//
// channel   direction  signals                      handshake
// -------   ---------  ---------------------------  -------------------------
// input     in         i_item, start, busy          taken when start & !busy
// result    out        o_result, o_strobe           one cycle, no back-pressure
// config    in         i_cfg_we, i_cfg_data         written when i_cfg_we
//
// - items load one per cycle when idle; an item beyond capacity is dropped
// - after the end-of-set item, row i of the exchange sort reads row i,
//   then scans the later rows with one memory read, so one compare, per
//   cycle, then writes its candidate back to row i
// - the sorted run then comes out one item per cycle, n items in all, and
//   busy drops after the final item
// - reset is synchronous, active low; it clears the count and the key select
// - the receiver cannot stall: each result is valid for its strobe cycle only
// ----------------------------------------------------------------------------
`default_nettype none

module record_exchange_sort_by_key_top #(
    parameter int CAPACITY = resbk_pkg::C_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire resbk_pkg::t_in_item           i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [resbk_pkg::C_KEY_W-1:0] i_cfg_data,
    output logic                               o_strobe,
    output resbk_pkg::t_out_item               o_result
);
    import resbk_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // state machine: load, per-row scan passes, output run
    resbk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_end_of_set (i_item.end_of_set),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .busy         (busy)
    );

    // record memory with the running candidate for row i
    resbk_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

/* tb/record_exchange_sort_by_key_checker.sv */
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key_checker
// watches the item, result and key channels of the sort block, rebuilds each
// sorted run on its own and compares every result field by field
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key_checker #(
    parameter int CAPACITY = resbk_pkg::C_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire resbk_pkg::t_in_item           i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [resbk_pkg::C_KEY_W-1:0] i_cfg_data,
    input  wire logic                          i_strobe,
    input  wire resbk_pkg::t_out_item          i_result,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import resbk_pkg::*;

    t_rec               held_recs [CAPACITY];
    int                 held_count = 0;
    logic [C_KEY_W-1:0] order_key  = C_KEY_FIRST;
    t_out_item          sorted_q [$];
    int                 fail_count = 0;
    int                 shown      = 0;

    function automatic logic [C_SCORE_W-1:0] rank_score(input t_rec r,
                                                        input logic [C_KEY_W-1:0] sel);
        logic [C_SCORE_W-1:0] s;
        case (sel)
            C_KEY_FIRST:  s = r.first;
            C_KEY_SECOND: s = r.second;
            default:      s = r.third;   // spare selector falls back on the third score
        endcase
        return s;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rec      tmp;
        t_out_item want;
        t_out_item res;
        logic      bad;
        if (!i_rst_n) begin
            held_count = 0;
            order_key  = C_KEY_FIRST;
            sorted_q.delete();
        end else begin
            // results first: no item is taken while a run is coming out
            if (i_strobe) begin
                if (sorted_q.size() == 0) begin
                    fail_count++;
                    if (shown < 10)
                        $display({"%0t: result with none expected: ",
                                  "id %h scores %h %h %h last %b"},
                                 $time, i_result.out_id, i_result.out_first,
                                 i_result.out_second, i_result.out_third,
                                 i_result.out_last);
                    shown++;
                end else begin
                    want = sorted_q.pop_front();
                    bad  = (i_result.out_id     !== want.out_id)     ||
                           (i_result.out_first  !== want.out_first)  ||
                           (i_result.out_second !== want.out_second) ||
                           (i_result.out_third  !== want.out_third)  ||
                           (i_result.out_last   !== want.out_last);
                    if (bad) begin
                        fail_count++;
                        if (shown < 10)
                            $display({"%0t: mismatch: expected id %h scores %h %h %h ",
                                      "last %b, got id %h scores %h %h %h last %b"},
                                     $time, want.out_id, want.out_first,
                                     want.out_second, want.out_third, want.out_last,
                                     i_result.out_id, i_result.out_first,
                                     i_result.out_second, i_result.out_third,
                                     i_result.out_last);
                        shown++;
                    end
                end
            end
            if (i_cfg_we)
                order_key = i_cfg_data;
            if (i_start && !i_busy) begin
                // records past capacity are dropped
                if (held_count < CAPACITY) begin
                    held_recs[held_count] = {i_item.record_id, i_item.score_first,
                                             i_item.score_second, i_item.score_third};
                    held_count++;
                end
                if (i_item.end_of_set) begin
                    // exchange sort, descending, ties left in place
                    for (int i = 0; i < held_count; i++)
                        for (int j = i; j < held_count; j++)
                            if (rank_score(held_recs[i], order_key) <
                                rank_score(held_recs[j], order_key)) begin
                                tmp          = held_recs[i];
                                held_recs[i] = held_recs[j];
                                held_recs[j] = tmp;
                            end
                    for (int i = 0; i < held_count; i++) begin
                        res.out_id     = held_recs[i].id;
                        res.out_first  = held_recs[i].first;
                        res.out_second = held_recs[i].second;
                        res.out_third  = held_recs[i].third;
                        res.out_last   = (i == held_count - 1);
                        sorted_q.insert(sorted_q.size(), res);
                    end
                    held_count = 0;
                end
            end
        end
        o_pending    <= sorted_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/tb_record_exchange_sort_by_key_top.sv */
// ----------------------------------------------------------------------------
// tb_record_exchange_sort_by_key_top
// drives record sets and key settings into the sort block; a checker beside
// it predicts each sorted run and counts mismatches for the final verdict
// ----------------------------------------------------------------------------
module tb_record_exchange_sort_by_key_top;
    import resbk_pkg::*;

    localparam int CAPACITY = C_CAPACITY;

    // key codes beyond the two that the package names
    localparam logic [C_KEY_W-1:0] KEY_THIRD = 2'd2;
    localparam logic [C_KEY_W-1:0] KEY_SPARE = 2'd3;

    localparam int ITEM_TARGET   = 100;
    localparam int IDLE_PCT      = 34;
    // the limit must outlast the sort of a full set, when nothing is accepted
    localparam int STALL_LIMIT   = 20000;
    // quiet cycles after the last result before a key write or the verdict
    localparam int SETTLE_CYCLES = 16;
    // a full store plus two dropped items, the last of which ends the set
    localparam int OVERFLOW_SET  = CAPACITY + 2;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_item           i_item;
    logic               i_cfg_we;
    logic [C_KEY_W-1:0] i_cfg_data;
    logic               o_strobe;
    t_out_item          o_result;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int sent_items   = 0;
    bit gaps_on      = 1'b1;

    always #5 i_clk = ~i_clk;

    record_exchange_sort_by_key_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // prediction and comparison live in the checker
    record_exchange_sort_by_key_checker #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: any item, result or key write restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one record and hold it until the block takes it; returns on the
    // accepting edge with start still high, so the caller either offers the
    // next item or lowers start in the same step
    task automatic send_record(input logic [C_ID_W-1:0]    id,
                               input logic [C_SCORE_W-1:0] s1,
                               input logic [C_SCORE_W-1:0] s2,
                               input logic [C_SCORE_W-1:0] s3,
                               input logic                 last);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= {id, s1, s2, s3, last};
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sent_items++;
    endtask

    // random set; narrow scores crowd the keys together so ties are common
    task automatic send_set(input int count, input bit narrow);
        for (int k = 0; k < count; k++) begin
            if (narrow)
                send_record(C_ID_W'($urandom), C_SCORE_W'($urandom_range(3)),
                            C_SCORE_W'($urandom_range(3)),
                            C_SCORE_W'($urandom_range(3)), k == count - 1);
            else
                send_record(C_ID_W'($urandom), C_SCORE_W'($urandom_range(255)),
                            C_SCORE_W'($urandom_range(255)),
                            C_SCORE_W'($urandom_range(255)), k == count - 1);
        end
    endtask

    // stop offering items and wait until every sorted run is out and the
    // block has gone idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // key write, only ever issued after drain
    task automatic write_key(input logic [C_KEY_W-1:0] key);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= key;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= C_KEY_FIRST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // key left at its reset value: single record set with extreme fields
        send_record(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 1'b1);

        // still first score: all-zero record, a tie at the top, a middle value
        send_record(16'h0000, 8'h00, 8'h00, 8'h00, 1'b0);
        send_record(16'h0001, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_record(16'h0002, 8'h80, 8'h7F, 8'hFF, 1'b0);
        send_record(16'h0003, 8'hFF, 8'h01, 8'h80, 1'b1);
        drain();

        // second score, fed in ascending order so every compare swaps
        write_key(C_KEY_SECOND);
        send_record(16'h1111, 8'hF0, 8'h01, 8'h10, 1'b0);
        send_record(16'h2222, 8'h70, 8'h02, 8'h20, 1'b0);
        send_record(16'h3333, 8'h00, 8'hFE, 8'h30, 1'b1);
        drain();

        // third score, all keys equal: order must not change
        write_key(KEY_THIRD);
        send_record(16'hA5A5, 8'h01, 8'h02, 8'h55, 1'b0);
        send_record(16'h5A5A, 8'h03, 8'h04, 8'h55, 1'b0);
        send_record(16'h8000, 8'h05, 8'h06, 8'h55, 1'b1);
        drain();

        // spare selector orders by the third score too
        write_key(KEY_SPARE);
        send_record(16'h0F0F, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_record(16'hF0F0, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_record(16'h7FFF, 8'h80, 8'h80, 8'h7F, 1'b0);
        send_record(16'h00FF, 8'h7F, 8'h7F, 8'h80, 1'b1);
        drain();
        write_key(C_KEY_FIRST);

        // random phases: a fresh key each time, sets queued back to back so
        // items wait on the sort and the output run; phase one overflows the
        // store, phase two runs with no idle cycles
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            write_key(C_KEY_W'($urandom_range(3)));
            gaps_on = (phase != 2);
            if (phase == 1)
                send_set(OVERFLOW_SET, 1'($urandom_range(1)));
            else
                repeat ((phase == 2) ? 4 : $urandom_range(1, 3))
                    send_set($urandom_range(1, 8), 1'($urandom_range(1)));
            drain();
            phase++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/resbk_pkg.sv
hw/rtl/resbk_ctrl.sv
hw/rtl/resbk_dp.sv
hw/rtl/record_exchange_sort_by_key_top.sv
tb/record_exchange_sort_by_key_checker.sv
tb/tb_record_exchange_sort_by_key_top.sv
